// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the multitap encoder rtl
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// condition that must never hold
`define ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/mte_pkg.sv =====
// types, constants and key tables for the multitap text encoder
// no dependencies
package mte_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // key symbol codes
  localparam logic [3:0] SYM_STAR  = 4'd10;
  localparam logic [3:0] SYM_HASH  = 4'd11;
  localparam logic [3:0] SYM_BAR   = 4'd12;
  localparam logic [3:0] KEY_SPACE = 4'd0;
  localparam logic [3:0] KEY_PUNCT = 4'd1;

  // ascii codes
  localparam logic [7:0] CHR_UPPER_A = 8'h41;
  localparam logic [7:0] CHR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHR_LOWER_A = 8'h61;
  localparam logic [7:0] CHR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CHR_DIGIT_0 = 8'h30;
  localparam logic [7:0] CHR_DIGIT_9 = 8'h39;
  localparam logic [7:0] CHR_SPACE   = 8'h20;
  localparam logic [7:0] CHR_PERIOD  = 8'h2E;
  localparam logic [7:0] CHR_COMMA   = 8'h2C;
  localparam logic [7:0] CHR_EXCLAIM = 8'h21;
  localparam logic [7:0] CHR_QUEST   = 8'h3F;

  // one classified character, ready for symbol emission
  typedef struct packed {
    logic       unsup;
    logic       bar;
    logic       hash;
    logic       star;
    logic [3:0] key;
    logic [2:0] presses;
  } job_t;

  function automatic logic [3:0] letter_key(input logic [4:0] idx);
    logic [3:0] k;
    case (idx)
      5'd0, 5'd1, 5'd2:            k = 4'd2;
      5'd3, 5'd4, 5'd5:            k = 4'd3;
      5'd6, 5'd7, 5'd8:            k = 4'd4;
      5'd9, 5'd10, 5'd11:          k = 4'd5;
      5'd12, 5'd13, 5'd14:         k = 4'd6;
      5'd15, 5'd16, 5'd17, 5'd18:  k = 4'd7;
      5'd19, 5'd20, 5'd21:         k = 4'd8;
      default:                     k = 4'd9;
    endcase
    return k;
  endfunction

  function automatic logic [2:0] letter_presses(input logic [4:0] idx);
    logic [2:0] p;
    case (idx)
      5'd0, 5'd3, 5'd6, 5'd9, 5'd12, 5'd15, 5'd19, 5'd22:  p = 3'd1;
      5'd1, 5'd4, 5'd7, 5'd10, 5'd13, 5'd16, 5'd20, 5'd23: p = 3'd2;
      5'd18, 5'd25:                                        p = 3'd4;
      default:                                             p = 3'd3;
    endcase
    return p;
  endfunction

endpackage

// ===== rtl/core/mte_if.sv =====
// valid/ready channel interfaces for characters in and key symbols out
// no dependencies
interface mte_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       start_of_message;

  modport source (output valid, output char_code, output start_of_message, input ready);
  modport sink   (input valid, input char_code, input start_of_message, output ready);
endinterface

interface mte_sym_if;
  logic       valid;
  logic       ready;
  logic [3:0] key_symbol;
  logic       last_of_run;
  logic       unsupported;

  modport source (output valid, output key_symbol, output last_of_run, output unsupported,
                  input ready);
  modport sink   (input valid, input key_symbol, input last_of_run, input unsupported,
                  output ready);
endinterface

// ===== rtl/core/mte_front.sv =====
// front end: classifies each character and keeps the message history
// depends on mte_pkg
module mte_front
  import mte_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       valid,
  output logic       ready,
  input  logic [7:0] char_code,
  input  logic       start_of_message,
  input  logic       full,
  output logic       push,
  output job_t       job
);

  logic       prev_valid;
  logic       prev_was_letter;
  logic       prev_was_upper;
  logic [3:0] prev_last_key;

  logic       is_upper, is_lower, is_letter, is_digit, is_punct, is_space;
  logic [4:0] idx;
  logic [3:0] first_key;
  logic       pv, pl, pu;
  logic [3:0] plk;
  logic [2:0] punct_presses;

  assign ready = !full;
  assign push  = valid && ready;

  always_comb begin
    is_upper  = char_code inside {[CHR_UPPER_A:CHR_UPPER_Z]};
    is_lower  = char_code inside {[CHR_LOWER_A:CHR_LOWER_Z]};
    is_letter = is_upper || is_lower;
    is_digit  = char_code inside {[CHR_DIGIT_0:CHR_DIGIT_9]};
    is_space  = char_code == CHR_SPACE;
    is_punct  = char_code inside {CHR_PERIOD, CHR_COMMA, CHR_EXCLAIM, CHR_QUEST};
    idx       = is_upper ? 5'(char_code - CHR_UPPER_A) : 5'(char_code - CHR_LOWER_A);

    case (char_code)
      CHR_PERIOD:  punct_presses = 3'd1;
      CHR_COMMA:   punct_presses = 3'd2;
      CHR_EXCLAIM: punct_presses = 3'd3;
      default:     punct_presses = 3'd4;
    endcase

    pv  = !start_of_message && prev_valid;
    pl  = !start_of_message && prev_was_letter;
    pu  = !start_of_message && prev_was_upper;
    plk = start_of_message ? 4'd0 : prev_last_key;

    job       = '0;
    first_key = KEY_SPACE;
    if (is_letter) begin
      job.key     = letter_key(idx);
      job.presses = letter_presses(idx);
      first_key   = job.key;
    end else if (is_digit) begin
      job.star    = 1'b1;
      job.key     = char_code[3:0];
      job.presses = 3'd1;
      first_key   = SYM_STAR;
    end else if (is_space) begin
      job.key     = KEY_SPACE;
      job.presses = 3'd1;
      first_key   = KEY_SPACE;
    end else if (is_punct) begin
      job.key     = KEY_PUNCT;
      job.presses = punct_presses;
      first_key   = KEY_PUNCT;
    end else begin
      job.unsup   = 1'b1;
      job.presses = 3'd1;
    end

    if (!job.unsup) begin
      job.bar  = pv && (plk == first_key);
      job.hash = is_letter && ((!pv && is_upper) || (pv && pl && (pu != is_upper)));
    end
  end

  // history moves only on supported characters
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_valid      <= 1'b0;
      prev_was_letter <= 1'b0;
      prev_was_upper  <= 1'b0;
      prev_last_key   <= 4'd0;
    end else if (push && !job.unsup) begin
      prev_valid      <= 1'b1;
      prev_was_letter <= is_letter;
      prev_was_upper  <= is_upper;
      prev_last_key   <= job.key;
    end
  end

endmodule

// ===== rtl/core/mte_queue.sv =====
// short job queue between front and back
// depends on mte_pkg, assert_macros.svh
`include "assert_macros.svh"
module mte_queue
  import mte_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output job_t head_job
);

  job_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full      = count == QCNT_W'(QUEUE_DEPTH);
  assign not_empty = count != '0;
  assign head_job  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `ASSERT_IMPL(a_no_overflow, clk, rst, push, !full)
  `ASSERT_IMPL(a_no_underflow, clk, rst, pop, not_empty)
  `ASSERT_NEVER(a_count_range, clk, rst, count > QCNT_W'(QUEUE_DEPTH))

endmodule

// ===== rtl/core/mte_back.sv =====
// back end: walks a job and emits its key symbols, one beat per unstalled cycle
// depends on mte_pkg, assert_macros.svh
`include "assert_macros.svh"
module mte_back
  import mte_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       not_empty,
  input  job_t       head_job,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] key_symbol,
  output logic       last_of_run,
  output logic       unsupported
);

  logic       busy;
  logic       bar, hash, star, unsup;
  logic [3:0] key;
  logic [2:0] presses;
  logic       advance;
  logic       last_now;
  logic       emit;

  assign advance  = !out_valid || out_ready;
  assign emit     = busy && advance;
  assign last_now = !bar && !hash && !star && (presses == 3'd1);
  assign pop      = not_empty && (!busy || (emit && last_now));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        busy <= 1'b1;
      end else if (emit && last_now) begin
        busy <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (advance) begin
        out_valid <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (emit) begin
      unsupported <= unsup;
      last_of_run <= last_now;
      if (bar) begin
        key_symbol <= SYM_BAR;
      end else if (hash) begin
        key_symbol <= SYM_HASH;
      end else if (star) begin
        key_symbol <= SYM_STAR;
      end else begin
        key_symbol <= key;
      end
    end
  end

  // job walk: a new job replaces the finished one
  always_ff @(posedge clk) begin
    if (pop) begin
      bar     <= head_job.bar;
      hash    <= head_job.hash;
      star    <= head_job.star;
      unsup   <= head_job.unsup;
      key     <= head_job.key;
      presses <= head_job.presses;
    end else if (emit) begin
      if (bar) begin
        bar <= 1'b0;
      end else if (hash) begin
        hash <= 1'b0;
      end else if (star) begin
        star <= 1'b0;
      end else begin
        presses <= presses - 1'b1;
      end
    end
  end

  `ASSERT_IMPL(a_unsup_single, clk, rst, out_valid && unsupported,
               last_of_run && (key_symbol == KEY_SPACE))
  `ASSERT_NEVER(a_sym_range, clk, rst, out_valid && (key_symbol > SYM_BAR))
  `ASSERT_NEXT(a_hold_stalled, clk, rst, out_valid && !out_ready,
               out_valid && $stable({key_symbol, last_of_run, unsupported}))

endmodule

// ===== rtl/core/multitap_text_encoder_unit.sv =====
// top level of the multitap keypad text encoder
// depends on mte_pkg, mte_if, mte_front, mte_queue, mte_back
//
//   channel    dir   beat contents
//   char_in    in    char_code[7:0], start_of_message
//   sym_out    out   key_symbol[3:0], last_of_run, unsupported
//
// a character is written to the queue when accepted, popped into the back's job
// registers, and its symbol beats then leave through the back's output register
// the back then emits one beat per cycle while sym_out is not stalled, 1 to 6 beats
// per character, set by the symbol count of its code; a queued next character follows on
// with no gap; the two-entry job queue lets the front accept while the back is emitting
// rst is synchronous; it clears the message history, queue and output valid
// a stalled sym_out holds its beat; char_in stalls only when the queue is full
module multitap_text_encoder_unit
  import mte_pkg::*;
(
  input logic       clk,
  input logic       rst,
  mte_char_if.sink  char_in,
  mte_sym_if.source sym_out
);

  // front to queue
  logic full;
  logic push;
  job_t push_job;

  // queue to back
  logic not_empty;
  logic pop;
  job_t head_job;

  // classify, apply history, build the job (bar, hash, star, key, presses)
  mte_front u_front (
    .clk              (clk),
    .rst              (rst),
    .valid            (char_in.valid),
    .ready            (char_in.ready),
    .char_code        (char_in.char_code),
    .start_of_message (char_in.start_of_message),
    .full             (full),
    .push             (push),
    .job              (push_job)
  );

  // decouples the front from output stalls
  mte_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .head_job  (head_job)
  );

  // emits bar, hash, star and key presses in order behind an output register
  mte_back u_back (
    .clk         (clk),
    .rst         (rst),
    .not_empty   (not_empty),
    .head_job    (head_job),
    .pop         (pop),
    .out_valid   (sym_out.valid),
    .out_ready   (sym_out.ready),
    .key_symbol  (sym_out.key_symbol),
    .last_of_run (sym_out.last_of_run),
    .unsupported (sym_out.unsupported)
  );

endmodule
